// ===== hw/rtl/pwrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrc_pkg
// shared types and constants of the pulse-width remote code transmitter
// ----------------------------------------------------------------------------
package pwrc_pkg;

   localparam int CODE_W        = 25;
   localparam int TICK_W        = 16;
   localparam int CNT_W         = 4;
   localparam int CODE_BITS_DEF = 25;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ON_CODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_CODE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_TICKS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TICKS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE_TICKS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE_PULSES = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_REPEATS   = 3'd6;

   // reset values
   localparam logic [CODE_W-1:0] RST_ON_CODE         = 25'd700;
   localparam logic [CODE_W-1:0] RST_OFF_CODE        = 25'd0;
   localparam logic [TICK_W-1:0] RST_SHORT_TICKS     = 16'd250;
   localparam logic [TICK_W-1:0] RST_LONG_TICKS      = 16'd500;
   localparam logic [TICK_W-1:0] RST_PREAMBLE_TICKS  = 16'd1000;
   localparam logic [CNT_W-1:0]  RST_PREAMBLE_PULSES = 4'd4;
   localparam logic [CNT_W-1:0]  RST_FRAME_REPEATS   = 4'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0] on_code;
      logic [CODE_W-1:0] off_code;
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] preamble_ticks;
      logic [CNT_W-1:0]  preamble_pulses;
      logic [CNT_W-1:0]  frame_repeats;
   } cfg_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic done_res;
      logic refused;
   } result_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_PRE  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pwrc_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrc_csr
// apb-style configuration registers
// ----------------------------------------------------------------------------
module pwrc_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [pwrc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [pwrc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pwrc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output pwrc_pkg::cfg_type                  cfg
);
   import pwrc_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ON_CODE:         cfg_in.on_code         = pwdata[CODE_W-1:0];
            REG_OFF_CODE:        cfg_in.off_code        = pwdata[CODE_W-1:0];
            REG_SHORT_TICKS:     cfg_in.short_ticks     = pwdata[TICK_W-1:0];
            REG_LONG_TICKS:      cfg_in.long_ticks      = pwdata[TICK_W-1:0];
            REG_PREAMBLE_TICKS:  cfg_in.preamble_ticks  = pwdata[TICK_W-1:0];
            REG_PREAMBLE_PULSES: cfg_in.preamble_pulses = pwdata[CNT_W-1:0];
            REG_FRAME_REPEATS:   cfg_in.frame_repeats   = pwdata[CNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ON_CODE:         prdata = CSR_DATA_W'(cfg_ff.on_code);
         REG_OFF_CODE:        prdata = CSR_DATA_W'(cfg_ff.off_code);
         REG_SHORT_TICKS:     prdata = CSR_DATA_W'(cfg_ff.short_ticks);
         REG_LONG_TICKS:      prdata = CSR_DATA_W'(cfg_ff.long_ticks);
         REG_PREAMBLE_TICKS:  prdata = CSR_DATA_W'(cfg_ff.preamble_ticks);
         REG_PREAMBLE_PULSES: prdata = CSR_DATA_W'(cfg_ff.preamble_pulses);
         REG_FRAME_REPEATS:   prdata = CSR_DATA_W'(cfg_ff.frame_repeats);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_code         <= RST_ON_CODE;
         cfg_ff.off_code        <= RST_OFF_CODE;
         cfg_ff.short_ticks     <= RST_SHORT_TICKS;
         cfg_ff.long_ticks      <= RST_LONG_TICKS;
         cfg_ff.preamble_ticks  <= RST_PREAMBLE_TICKS;
         cfg_ff.preamble_pulses <= RST_PREAMBLE_PULSES;
         cfg_ff.frame_repeats   <= RST_FRAME_REPEATS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pwrc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwrc_core
// transmission sequencer: one item per cycle while fire is high, result combinational
// ----------------------------------------------------------------------------
module pwrc_core #(
   parameter int CODE_BITS = pwrc_pkg::CODE_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 fire,
   input  wire                 op,
   input  wire                 turn_on,
   input  pwrc_pkg::cfg_type   cfg,
   output pwrc_pkg::result_type result
);
   import pwrc_pkg::*;

   localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_BITS - 1);

   phase_type             phase_ff, phase_in;
   logic                  high_ff, high_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [IDX_W-1:0]      bit_ff, bit_in;
   logic [CNT_W-1:0]      pulse_ff, pulse_in;
   logic [CNT_W-1:0]      rep_ff, rep_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;

   logic [CODE_W-1:0]     code_sel;
   logic [CODE_BITS-1:0]  code_fit;
   logic [IDX_W-1:0]      pos;
   logic                  cur_bit;
   logic [TICK_W-1:0]     len_raw, half_len, tick_inc;
   logic                  half_end;
   logic [CNT_W-1:0]      pulse_inc, rep_inc, rep_lim;

   assign code_sel = turn_on ? cfg.on_code : cfg.off_code;

   // fit the 25-bit code word to the sent width
   generate
      if (CODE_BITS >= CODE_W) begin : g_ext
         assign code_fit = CODE_BITS'(code_sel);
      end else begin : g_trunc
         assign code_fit = code_sel[CODE_BITS-1:0];
      end
   endgenerate

   assign pos     = LAST_IDX - bit_ff;
   assign cur_bit = code_ff[pos];

   always_comb begin
      if (phase_ff == PH_PRE)
         len_raw = cfg.preamble_ticks;
      else if (high_ff)
         len_raw = cur_bit ? cfg.long_ticks : cfg.short_ticks;
      else
         len_raw = cur_bit ? cfg.short_ticks : cfg.long_ticks;
   end

   assign half_len  = (len_raw == '0) ? TICK_W'(1) : len_raw;
   assign tick_inc  = tick_ff + TICK_W'(1);
   assign half_end  = tick_inc >= half_len;
   assign pulse_inc = pulse_ff + CNT_W'(1);
   assign rep_inc   = rep_ff + CNT_W'(1);
   assign rep_lim   = (cfg.frame_repeats == '0) ? CNT_W'(1) : cfg.frame_repeats;

   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      pulse_in = pulse_ff;
      rep_in   = rep_ff;
      code_in  = code_ff;
      result   = '0;
      if (op == OP_START) begin
         result.busy_res = 1'b1;
         if (phase_ff != PH_IDLE) begin
            result.refused = 1'b1;
         end else begin
            code_in  = code_fit;
            rep_in   = '0;
            pulse_in = '0;
            bit_in   = '0;
            tick_in  = '0;
            high_in  = 1'b1;
            phase_in = (cfg.preamble_pulses == '0) ? PH_DATA : PH_PRE;
         end
      end else if (phase_ff != PH_IDLE) begin
         result.busy_res   = 1'b1;
         result.line_level = high_ff;
         tick_in           = tick_inc;
         if (half_end) begin
            tick_in = '0;
            if (high_ff) begin
               high_in = 1'b0;
            end else begin
               high_in = 1'b1;
               unique case (phase_ff)
                  PH_PRE: begin
                     pulse_in = pulse_inc;
                     if (pulse_inc >= cfg.preamble_pulses) begin
                        phase_in = PH_DATA;
                        bit_in   = '0;
                     end
                  end
                  PH_DATA: begin
                     bit_in = bit_ff + IDX_W'(1);
                     if (bit_ff == LAST_IDX) begin
                        rep_in = rep_inc;
                        bit_in = '0;
                        if (rep_inc >= rep_lim) begin
                           phase_in        = PH_IDLE;
                           high_in         = 1'b0;
                           pulse_in        = '0;
                           rep_in          = '0;
                           result.done_res = 1'b1;
                        end else begin
                           pulse_in = '0;
                           phase_in = (cfg.preamble_pulses == '0) ? PH_DATA : PH_PRE;
                        end
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         high_ff  <= 1'b0;
         tick_ff  <= '0;
         bit_ff   <= '0;
         pulse_ff <= '0;
         rep_ff   <= '0;
         code_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         pulse_ff <= pulse_in;
         rep_ff   <= rep_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pulse_width_remote_code_transmitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_remote_code_transmitter_top
// pulse-width on-off keyed line driver with apb-style configuration
// ----------------------------------------------------------------------------
// One item is taken per clock cycle, sustained, while the result output is
// not stalled, and each item gives exactly one result. An item enters the
// input register; when it advances, the sequencer state updates and the
// result register loads in the same cycle. The sequencer's state update is
// combinational counter compares between the two registers. A stalled
// result keeps the next item waiting in the input register, and the input
// stalls only while both registers are full. A start item latches the on or
// off code; each following tick item reports the line level for one
// microsecond of line time, with busy, and done on the last low tick. A
// start while a transmission runs is refused and flagged. Configuration is
// read live on every tick, so write it only while no item is in flight.
// ----------------------------------------------------------------------------
module pulse_width_remote_code_transmitter_top #(
   parameter int CODE_BITS = pwrc_pkg::CODE_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // item input
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_op,
   input  wire                               req_turn_on,
   // result output
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_line_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic                              rsp_refused,
   // configuration
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [pwrc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire  [pwrc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pwrc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import pwrc_pkg::*;

   cfg_type    cfg;
   result_type core_result;
   result_type out_ff;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_op_ff, in_turn_on_ff;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic take;

   // the input stage moves on whenever the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   pwrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer state moves only when the item enters the result register
   pwrc_core #(
      .CODE_BITS (CODE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .op      (in_op_ff),
      .turn_on (in_turn_on_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff      <= req_op;
         in_turn_on_ff <= req_turn_on;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_level = out_ff.line_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_refused    = out_ff.refused;

   // done only ever closes a running transmission
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res && !rsp_refused)
      else $error("done without busy");

   // a refused start passes no line time
   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> rsp_busy_res && !rsp_line_level)
      else $error("refused start drove the line");

   // the line is never high outside a transmission
   a_level_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_level |-> rsp_busy_res)
      else $error("line high while idle");

   // an item held in the input stage forces a stall upstream
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && req_stall |=> req_stall || !rsp_stall)
      else $error("input stage lost while output stalled");

endmodule
`default_nettype wire
